>>> hdl/crc32fc_pkg.sv
// crc32fc_pkg: shared constants, types and the byte-wide CRC-32 update
// for the CRC-32 frame checker. No dependencies.
`default_nettype none

package crc32fc_pkg;

    localparam int MAX_FRAME_BYTES = 1024;
    localparam int CRC_BYTES       = 4;
    localparam int HEADER_BYTES    = 8;
    localparam int BYTE_W          = 8;
    localparam int CRC_W           = 32;
    localparam int ID_W            = 32;
    localparam int PLEN_W          = 10;
    localparam int IDX_W           = $clog2(MAX_FRAME_BYTES + 1);
    localparam int SUB_W           = $clog2(CRC_BYTES);
    localparam int QUEUE_DEPTH     = 4;
    localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CRC_W-1:0] CRC_POLY_REFLECTED = 32'hEDB8_8320;
    localparam logic [CRC_W-1:0] CRC_INIT           = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        STATUS_OK,
        STATUS_CRC_ERROR,
        STATUS_TOO_SHORT,
        STATUS_TOO_LONG
    } frame_status_t;

    // byte class decided by the front end
    typedef enum logic [1:0] {
        KIND_HDR_CRC,
        KIND_HDR_ID,
        KIND_PAYLOAD,
        KIND_OVERFLOW
    } byte_kind_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
        byte_kind_t        kind;
        logic [SUB_W-1:0]  sub;    // byte lane within crc or id word
        logic [IDX_W-1:0]  count;  // frame bytes counted including this one, saturating at MAX_FRAME_BYTES
    } entry_t;

    function automatic logic [CRC_W-1:0] crc_update_byte(
        input logic [CRC_W-1:0]  crc_in,
        input logic [BYTE_W-1:0] data
    );
        logic [CRC_W-1:0] c;
        c = crc_in ^ {{(CRC_W-BYTE_W){1'b0}}, data};
        for (int k = 0; k < BYTE_W; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY_REFLECTED;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> hdl/crc32fc_if.sv
// Channel interfaces for the CRC-32 frame checker: input byte beats and
// result beats. Depends on crc32fc_pkg.
`default_nettype none

interface crc32fc_in_if;
    logic                             valid;
    logic                             ready;
    logic [crc32fc_pkg::BYTE_W-1:0]   rx_byte;
    logic                             frame_end;

    modport source (output valid, output rx_byte, output frame_end, input ready);
    modport sink   (input valid, input rx_byte, input frame_end, output ready);
endinterface

interface crc32fc_out_if;
    logic                             valid;
    logic                             ready;
    logic [crc32fc_pkg::BYTE_W-1:0]   payload_byte;
    logic                             payload_valid;
    logic                             frame_done;
    logic [1:0]                       frame_status;
    logic signed [crc32fc_pkg::ID_W-1:0] packet_id;
    logic [crc32fc_pkg::PLEN_W-1:0]   payload_length;

    modport source (output valid, output payload_byte, output payload_valid,
                    output frame_done, output frame_status, output packet_id,
                    output payload_length, input ready);
    modport sink   (input valid, input payload_byte, input payload_valid,
                    input frame_done, input frame_status, input packet_id,
                    input payload_length, output ready);
endinterface

`default_nettype wire

>>> hdl/crc32fc_front.sv
// crc32fc_front: accepts byte beats, tracks the position in the frame and
// tags each byte with its class. Depends on crc32fc_pkg, crc32fc_if.
`default_nettype none

module crc32fc_front (
    input  logic                clk,
    input  logic                rst_n,
    crc32fc_in_if.sink          bytes,
    input  logic                push_ready,
    output logic                push_valid,
    output crc32fc_pkg::entry_t push_entry
);

    logic [crc32fc_pkg::IDX_W-1:0] idx_reg;
    logic [crc32fc_pkg::IDX_W-1:0] idx_next;
    logic                          take;
    logic                          saturated;

    assign bytes.ready = push_ready;
    assign take        = bytes.valid && push_ready;
    assign push_valid  = take;
    assign saturated   = idx_reg >= crc32fc_pkg::IDX_W'(crc32fc_pkg::MAX_FRAME_BYTES);

    always_comb
    begin
        push_entry.data = bytes.rx_byte;
        push_entry.last = bytes.frame_end;
        push_entry.sub  = idx_reg[crc32fc_pkg::SUB_W-1:0];
        if (saturated)
        begin
            push_entry.kind = crc32fc_pkg::KIND_OVERFLOW;
            idx_next        = idx_reg;
        end
        else
        begin
            if (idx_reg < crc32fc_pkg::IDX_W'(crc32fc_pkg::CRC_BYTES))
                push_entry.kind = crc32fc_pkg::KIND_HDR_CRC;
            else if (idx_reg < crc32fc_pkg::IDX_W'(crc32fc_pkg::HEADER_BYTES))
                push_entry.kind = crc32fc_pkg::KIND_HDR_ID;
            else
                push_entry.kind = crc32fc_pkg::KIND_PAYLOAD;
            idx_next = idx_reg + crc32fc_pkg::IDX_W'(1);
        end
        push_entry.count = idx_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= '0;
        else if (take)
            idx_reg <= bytes.frame_end ? '0 : idx_next;
    end

endmodule

`default_nettype wire

>>> hdl/crc32fc_queue.sv
// crc32fc_queue: short register FIFO of classified bytes between front and
// back end. Depends on crc32fc_pkg.
`default_nettype none

module crc32fc_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    input  crc32fc_pkg::entry_t push_entry,
    output logic                push_ready,
    input  logic                pop,
    output logic                pop_valid,
    output crc32fc_pkg::entry_t head
);

    crc32fc_pkg::entry_t            slot_reg [crc32fc_pkg::QUEUE_DEPTH];
    logic [crc32fc_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [crc32fc_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [crc32fc_pkg::QCNT_W-1:0] count_reg;
    logic                           do_push;
    logic                           do_pop;

    localparam logic [crc32fc_pkg::QPTR_W-1:0] LAST_PTR =
        crc32fc_pkg::QPTR_W'(crc32fc_pkg::QUEUE_DEPTH - 1);

    assign push_ready = count_reg != crc32fc_pkg::QCNT_W'(crc32fc_pkg::QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;
    assign head       = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0
                            : wr_ptr_reg + crc32fc_pkg::QPTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0
                            : rd_ptr_reg + crc32fc_pkg::QPTR_W'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + crc32fc_pkg::QCNT_W'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - crc32fc_pkg::QCNT_W'(1);
        end
    end

endmodule

`default_nettype wire

>>> hdl/crc32fc_back.sv
// crc32fc_back: runs the CRC, collects header fields, judges the frame and
// drives the result register. Depends on crc32fc_pkg, crc32fc_if.
`default_nettype none

module crc32fc_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pop_valid,
    input  crc32fc_pkg::entry_t head,
    output logic                pop,
    crc32fc_out_if.source       results
);

    logic [crc32fc_pkg::CRC_W-1:0] crc_reg,  crc_next;
    logic [crc32fc_pkg::CRC_W-1:0] hcrc_reg, hcrc_next;
    logic [crc32fc_pkg::ID_W-1:0]  id_reg,   id_next;
    logic                          ovf_reg,  ovf_next;
    logic [crc32fc_pkg::CRC_W-1:0] crc_upd;
    logic [crc32fc_pkg::IDX_W-1:0] plen_full;
    logic [4:0]                    lane_bit;

    logic                              out_valid_reg;
    logic [crc32fc_pkg::BYTE_W-1:0]    out_byte_reg,   out_byte_next;
    logic                              out_pay_reg,    out_pay_next;
    logic                              out_done_reg,   out_done_next;
    crc32fc_pkg::frame_status_t        out_status_reg, out_status_next;
    logic [crc32fc_pkg::ID_W-1:0]      out_id_reg,     out_id_next;
    logic [crc32fc_pkg::PLEN_W-1:0]    out_plen_reg,   out_plen_next;
    logic                              has_result;

    assign pop      = pop_valid && (!out_valid_reg || results.ready);
    assign crc_upd  = crc32fc_pkg::crc_update_byte(crc_reg, head.data);
    assign lane_bit = {head.sub, 3'b000};
    assign plen_full = head.count - crc32fc_pkg::IDX_W'(crc32fc_pkg::HEADER_BYTES);

    always_comb
    begin
        crc_next     = crc_reg;
        hcrc_next    = hcrc_reg;
        id_next      = id_reg;
        ovf_next     = ovf_reg;
        out_pay_next = 1'b0;
        case (head.kind)
            crc32fc_pkg::KIND_HDR_CRC:
            begin
                hcrc_next[lane_bit +: 8] = head.data;
            end
            crc32fc_pkg::KIND_HDR_ID:
            begin
                id_next[lane_bit +: 8] = head.data;
                crc_next               = crc_upd;
            end
            crc32fc_pkg::KIND_PAYLOAD:
            begin
                crc_next     = crc_upd;
                out_pay_next = 1'b1;
            end
            crc32fc_pkg::KIND_OVERFLOW:
            begin
                ovf_next = 1'b1;
            end
            default:
            begin
                crc_next = crc_reg;
            end
        endcase

        out_byte_next   = out_pay_next ? head.data : '0;
        out_done_next   = head.last;
        out_status_next = crc32fc_pkg::STATUS_OK;
        out_id_next     = '0;
        out_plen_next   = '0;
        if (head.last)
        begin
            if (head.count < crc32fc_pkg::IDX_W'(crc32fc_pkg::HEADER_BYTES))
                out_status_next = crc32fc_pkg::STATUS_TOO_SHORT;
            else
            begin
                out_id_next   = id_next;
                out_plen_next = crc32fc_pkg::PLEN_W'(plen_full);
                if (ovf_next)
                    out_status_next = crc32fc_pkg::STATUS_TOO_LONG;
                else if ((crc_next ^ crc32fc_pkg::CRC_INIT) != hcrc_next)
                    out_status_next = crc32fc_pkg::STATUS_CRC_ERROR;
                else
                    out_status_next = crc32fc_pkg::STATUS_OK;
            end
        end
        has_result = out_pay_next || head.last;
    end

    // frame state; back to reset values after the last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg  <= crc32fc_pkg::CRC_INIT;
            hcrc_reg <= '0;
            id_reg   <= '0;
            ovf_reg  <= 1'b0;
        end
        else if (pop)
        begin
            if (head.last)
            begin
                crc_reg  <= crc32fc_pkg::CRC_INIT;
                hcrc_reg <= '0;
                id_reg   <= '0;
                ovf_reg  <= 1'b0;
            end
            else
            begin
                crc_reg  <= crc_next;
                hcrc_reg <= hcrc_next;
                id_reg   <= id_next;
                ovf_reg  <= ovf_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (pop && has_result)
            out_valid_reg <= 1'b1;
        else if (results.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (pop && has_result)
        begin
            out_byte_reg   <= out_byte_next;
            out_pay_reg    <= out_pay_next;
            out_done_reg   <= out_done_next;
            out_status_reg <= out_status_next;
            out_id_reg     <= out_id_next;
            out_plen_reg   <= out_plen_next;
        end
    end

    assign results.valid          = out_valid_reg;
    assign results.payload_byte   = out_byte_reg;
    assign results.payload_valid  = out_pay_reg;
    assign results.frame_done     = out_done_reg;
    assign results.frame_status   = out_status_reg;
    assign results.packet_id      = out_id_reg;
    assign results.payload_length = out_plen_reg;

endmodule

`default_nettype wire

>>> hdl/crc32_frame_checker.sv
// crc32_frame_checker: top level of the CRC-32 frame checker / deframer.
// Depends on crc32fc_pkg, crc32fc_if, crc32fc_front, crc32fc_queue, crc32fc_back.
//
//   channel   dir  beat contents
//   -------   ---  ------------------------------------------------------------
//   bytes     in   rx_byte, frame_end (one datagram byte per beat)
//   results   out  payload_byte, payload_valid, frame_done, frame_status,
//                  packet_id, payload_length (one beat per payload byte or frame end)
//
// One byte per cycle sustained while the queue has room. An accepted byte is written
// into the queue; the back end moves it from the queue head into the output register
// once that register is empty or being read, raising results.valid if it yields a result.
// The byte-wide CRC-32 update and status compare in the back end set the cycle.
// Reset is asynchronous, active low; no clearing pass is needed.
// A 4-beat queue between front and back absorbs result-side stalls; bytes.ready
// drops only when that queue is full. Header-only bytes produce no result beat.
`default_nettype none

module crc32_frame_checker (
    input  logic          clk,
    input  logic          rst_n,
    crc32fc_in_if.sink    bytes,
    crc32fc_out_if.source results
);

    logic                push_valid;
    logic                push_ready;
    crc32fc_pkg::entry_t push_entry;
    logic                pop;
    logic                pop_valid;
    crc32fc_pkg::entry_t head;

    // front: position tracking and byte classification
    crc32fc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .bytes      (bytes),
        .push_ready (push_ready),
        .push_valid (push_valid),
        .push_entry (push_entry)
    );

    // decoupling queue
    crc32fc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .push_ready (push_ready),
        .pop        (pop),
        .pop_valid  (pop_valid),
        .head       (head)
    );

    // back: CRC, header capture, status, result register
    crc32fc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .head      (head),
        .pop       (pop),
        .results   (results)
    );

    // back end never pops an empty queue
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> pop_valid)
        else $error("pop from empty queue");

    // every pushed byte is accepted from the input channel
    a_push_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        push_valid |-> (bytes.valid && push_ready))
        else $error("push without input accept");

    // a result that does not end a frame must carry payload
    a_result_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && !results.frame_done) |-> results.payload_valid)
        else $error("empty result beat");

    // short frames report no id and no length
    a_short_zeroed: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.frame_done &&
         results.frame_status == crc32fc_pkg::STATUS_TOO_SHORT)
        |-> (results.packet_id == '0 && results.payload_length == '0
             && !results.payload_valid))
        else $error("short frame with id or length");

endmodule

`default_nettype wire

>>> test/crc32fc_result_checker.sv
`timescale 1ns / 1ps
// crc32fc_result_checker: watches the byte and result channels of the CRC-32
// frame checker, predicts each result beat and compares it. Needs crc32fc_pkg, crc32fc_if.

module crc32fc_result_checker
    import crc32fc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    crc32fc_in_if       rx_mon,
    crc32fc_out_if      res_mon,
    output int unsigned mismatch_count,
    output int unsigned open_beats
);

    localparam logic [CRC_W-1:0] POLY_REV     = 32'hEDB8_8320;
    localparam int               REPORT_LIMIT = 10;

    typedef struct packed {
        logic [BYTE_W-1:0]      payload_byte;
        logic                   payload_valid;
        logic                   frame_done;
        frame_status_t          frame_status;
        logic signed [ID_W-1:0] packet_id;
        logic [PLEN_W-1:0]      payload_length;
    } result_beat_t;

    result_beat_t     awaited_results[$];
    int unsigned      faults;

    // model of the frame in flight
    logic [IDX_W-1:0] frame_pos;
    logic [CRC_W-1:0] crc_acc;
    logic [CRC_W-1:0] crc_field;
    logic [ID_W-1:0]  id_field;
    logic             over_flag;

    function automatic logic [CRC_W-1:0] crc_fold_byte(
        input logic [CRC_W-1:0]  c,
        input logic [BYTE_W-1:0] b
    );
        logic [CRC_W-1:0] r;
        r = c ^ CRC_W'(b);
        repeat (BYTE_W)
            r = (r >> 1) ^ (POLY_REV & {CRC_W{r[0]}});
        return r;
    endfunction

    task automatic clear_frame();
        frame_pos = '0;
        crc_acc   = CRC_INIT;
        crc_field = '0;
        id_field  = '0;
        over_flag = 1'b0;
    endtask

    task automatic absorb_rx_byte(input logic [BYTE_W-1:0] b, input logic last);
        result_beat_t r;
        int           pos;
        r   = '0;
        pos = int'(frame_pos);
        if (pos >= MAX_FRAME_BYTES)
            over_flag = 1'b1;
        else
        begin
            if (pos < CRC_BYTES)
                crc_field[BYTE_W*pos +: BYTE_W] = b;
            else
            begin
                if (pos < HEADER_BYTES)
                    id_field[BYTE_W*(pos-CRC_BYTES) +: BYTE_W] = b;
                else
                begin
                    r.payload_byte  = b;
                    r.payload_valid = 1'b1;
                end
                crc_acc = crc_fold_byte(crc_acc, b);
            end
            frame_pos = frame_pos + 1'b1;
        end
        if (last)
        begin
            r.frame_done = 1'b1;
            if (frame_pos < HEADER_BYTES)
                r.frame_status = STATUS_TOO_SHORT;
            else
            begin
                r.packet_id      = id_field;
                r.payload_length = PLEN_W'(frame_pos - HEADER_BYTES);
                if (over_flag)
                    r.frame_status = STATUS_TOO_LONG;
                else if ((crc_acc ^ CRC_INIT) != crc_field)
                    r.frame_status = STATUS_CRC_ERROR;
                else
                    r.frame_status = STATUS_OK;
            end
            clear_frame();
        end
        if (r.payload_valid || r.frame_done)
            awaited_results.push_back(r);
    endtask

    task automatic judge_result();
        result_beat_t want;
        result_beat_t got;
        got.payload_byte   = res_mon.payload_byte;
        got.payload_valid  = res_mon.payload_valid;
        got.frame_done     = res_mon.frame_done;
        got.frame_status   = frame_status_t'(res_mon.frame_status);
        got.packet_id      = res_mon.packet_id;
        got.payload_length = res_mon.payload_length;
        if (awaited_results.size() == 0)
        begin
            if (faults < REPORT_LIMIT)
                $display("%0t: result beat with none awaited: byte=%02h pv=%0b done=%0b",
                         $realtime, got.payload_byte, got.payload_valid, got.frame_done);
            faults++;
            return;
        end
        want = awaited_results.pop_front();
        if (got.payload_byte !== want.payload_byte || got.payload_valid !== want.payload_valid
            || got.frame_done !== want.frame_done || got.frame_status !== want.frame_status
            || got.packet_id !== want.packet_id || got.payload_length !== want.payload_length)
        begin
            if (faults < REPORT_LIMIT)
            begin
                $display("%0t: result mismatch", $realtime);
                $display("  expected byte=%02h pv=%0b done=%0b status=%0d id=%0d len=%0d",
                         want.payload_byte, want.payload_valid, want.frame_done,
                         want.frame_status, want.packet_id, want.payload_length);
                $display("  actual   byte=%02h pv=%0b done=%0b status=%0d id=%0d len=%0d",
                         got.payload_byte, got.payload_valid, got.frame_done,
                         got.frame_status, got.packet_id, got.payload_length);
            end
            faults++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_frame();
            awaited_results.delete();
            faults = 0;
            mismatch_count <= 0;
            open_beats     <= 0;
        end
        else
        begin
            // results first: a byte taken at this edge cannot be the one leaving
            if (res_mon.valid && res_mon.ready)
                judge_result();
            if (rx_mon.valid && rx_mon.ready)
                absorb_rx_byte(rx_mon.rx_byte, rx_mon.frame_end);
            mismatch_count <= faults;
            open_beats     <= awaited_results.size();
        end
    end

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// testbench: top of the CRC-32 frame checker bench. Sends datagrams byte by byte,
// back-pressures the result side and gives the verdict. Needs crc32fc_pkg,
// crc32fc_if, crc32_frame_checker and crc32fc_result_checker.

module testbench;
    import crc32fc_pkg::*;

    // Every random frame, the one past the buffer size included, counts toward
    // the byte budget.
    localparam int RANDOM_BYTES = 1550;
    localparam int CALM_BYTES   = 250;   // tail of the run with no idling at all
    // Longest legal quiet stretch is one gap or stall burst plus the pipeline through
    // the queue and output register; this is far beyond it.
    localparam int STUCK_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 20;
    localparam logic [CRC_W-1:0] POLY_REV = 32'hEDB8_8320;

    logic              clk = 1'b0;
    logic              rst_n;
    int unsigned       mismatch_count;
    int unsigned       open_beats;

    // idling controls: percent chance of starting an idle burst; gaps are drawn per byte beat
    int unsigned       gap_pct      = 0;
    int unsigned       stall_pct    = 0;
    int unsigned       stall_left   = 0;
    int unsigned       stuck_cycles = 0;
    int unsigned       idle_levels[5] = '{0, 0, 10, 30, 60};

    logic [BYTE_W-1:0] frame_bytes[$];   // datagram being sent

    crc32fc_in_if  byte_ch ();
    crc32fc_out_if result_ch ();

    crc32_frame_checker i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .bytes   (byte_ch),
        .results (result_ch)
    );

    crc32fc_result_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .rx_mon         (byte_ch),
        .res_mon        (result_ch),
        .mismatch_count (mismatch_count),
        .open_beats     (open_beats)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Result-side back-pressure: ready drops in bursts while stall_pct allows.
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left      <= stall_left - 1;
            result_ch.ready <= 1'b0;
        end
        else if (stall_pct != 0 && $urandom_range(99) < stall_pct)
        begin
            stall_left      <= $urandom_range(12, 0);
            result_ch.ready <= 1'b0;
        end
        else
            result_ch.ready <= 1'b1;
    end

    // Watchdog: too long without any beat on either channel means a hang.
    always @(posedge clk)
    begin
        if (!rst_n || (byte_ch.valid && byte_ch.ready) || (result_ch.valid && result_ch.ready))
            stuck_cycles <= 0;
        else if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("FAIL crc32_frame_checker");
            $finish;
        end
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    function automatic logic [CRC_W-1:0] crc_of_byte(
        input logic [CRC_W-1:0]  c,
        input logic [BYTE_W-1:0] b
    );
        logic [CRC_W-1:0] r;
        r = c ^ CRC_W'(b);
        repeat (BYTE_W)
            r = r[0] ? ((r >> 1) ^ POLY_REV) : (r >> 1);
        return r;
    endfunction

    // One byte beat; valid stays up into the next beat unless a gap is drawn.
    task automatic put_byte(input logic [BYTE_W-1:0] b, input logic last);
        int unsigned gap;
        if (gap_pct != 0 && $urandom_range(99) < gap_pct)
        begin
            gap = $urandom_range(13, 1);
            byte_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_ch.valid     <= 1'b1;
        byte_ch.rx_byte   <= b;
        byte_ch.frame_end <= last;
        do
            @(posedge clk);
        while (!byte_ch.ready);
    endtask

    task automatic ship_frame();
        int k;
        for (k = 0; k < frame_bytes.size(); k++)
            put_byte(frame_bytes[k], k == frame_bytes.size() - 1);
    endtask

    // Well-formed datagram of total_len bytes (at least the header). Bytes past
    // the buffer size stay out of the CRC, as the block ignores them.
    task automatic make_frame(input int total_len, input logic [ID_W-1:0] id, input bit crc_good);
        logic [CRC_W-1:0]  crc;
        logic [BYTE_W-1:0] b;
        int                k;
        crc = CRC_INIT;
        frame_bytes.delete();
        for (k = 0; k < ID_W / BYTE_W; k++)
        begin
            b = id[BYTE_W*k +: BYTE_W];
            frame_bytes.push_back(b);
            crc = crc_of_byte(crc, b);
        end
        for (k = HEADER_BYTES; k < total_len; k++)
        begin
            b = BYTE_W'($urandom);
            frame_bytes.push_back(b);
            if (k < MAX_FRAME_BYTES)
                crc = crc_of_byte(crc, b);
        end
        crc = crc ^ CRC_INIT;
        if (!crc_good)
            crc = crc ^ (32'h1 << $urandom_range(31));
        // little-endian CRC goes in front
        for (k = CRC_BYTES - 1; k >= 0; k--)
            frame_bytes.push_front(crc[BYTE_W*k +: BYTE_W]);
    endtask

    initial
    begin : stimulus
        int unsigned     sent_bytes;
        int unsigned     frame_no;
        int unsigned     kind;
        int unsigned     plen;
        int unsigned     len;
        logic [ID_W-1:0] id;

        rst_n             <= 1'b0;
        byte_ch.valid     <= 1'b0;
        byte_ch.rx_byte   <= '0;
        byte_ch.frame_end <= 1'b0;
        gap_pct   = 30;
        stall_pct = 30;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: shortest possible frame, a frame one byte short of a
        // header, a header-only frame with the most negative id, and a
        // one-byte payload with a corrupted CRC and the most positive id.
        frame_bytes.delete();
        frame_bytes.push_back(8'hFF);
        ship_frame();
        frame_bytes.delete();
        frame_bytes.push_back(8'h00);
        frame_bytes.push_back(8'hFF);
        frame_bytes.push_back(8'h55);
        frame_bytes.push_back(8'hAA);
        frame_bytes.push_back(8'h01);
        frame_bytes.push_back(8'h80);
        frame_bytes.push_back(8'h7F);
        ship_frame();
        make_frame(HEADER_BYTES, 32'h8000_0000, 1'b1);
        ship_frame();
        make_frame(HEADER_BYTES + 1, 32'h7FFF_FFFF, 1'b0);
        ship_frame();

        // Random: mostly good frames with random content, some CRC errors,
        // runts and plain noise. Idling levels change every couple dozen frames.
        sent_bytes = 0;
        frame_no   = 0;
        while (sent_bytes < RANDOM_BYTES)
        begin
            if (sent_bytes >= RANDOM_BYTES - CALM_BYTES)
            begin
                gap_pct   = 0;
                stall_pct = 0;
            end
            else if (frame_no % 24 == 0)
            begin
                gap_pct   = idle_levels[$urandom_range(4)];
                stall_pct = idle_levels[$urandom_range(4)];
            end

            if (frame_no == 12)
            begin
                // overflow with a bad CRC too: too_long must win, and the
                // length saturates at MAX_FRAME_BYTES - HEADER_BYTES
                make_frame(MAX_FRAME_BYTES + $urandom_range(6, 1), $urandom, 1'b0);
            end
            else
            begin
                case ($urandom_range(9))
                    0:       id = '0;
                    1:       id = '1;
                    2:       id = 32'h8000_0000;
                    3:       id = 32'h7FFF_FFFF;
                    default: id = $urandom;
                endcase
                plen = ($urandom_range(4) != 0) ? $urandom_range(16) : $urandom_range(80, 17);
                kind = $urandom_range(99);
                if (kind < 65)
                    make_frame(HEADER_BYTES + plen, id, 1'b1);
                else if (kind < 80)
                    make_frame(HEADER_BYTES + plen, id, 1'b0);
                else
                begin
                    len = (kind < 90) ? $urandom_range(HEADER_BYTES - 1, 1)
                                      : $urandom_range(30, 1);
                    frame_bytes.delete();
                    repeat (len)
                        frame_bytes.push_back(BYTE_W'($urandom));
                end
            end
            ship_frame();
            sent_bytes += frame_bytes.size();
            frame_no++;
        end
        byte_ch.valid <= 1'b0;

        // let the checker see the last byte, then wait for every result
        @(posedge clk);
        while (open_beats != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && open_beats == 0)
            $display("PASS crc32_frame_checker");
        else
            $display("FAIL crc32_frame_checker");
        $finish;
    end

endmodule
